>>> hw/rtl/mexp_pkg.sv
`default_nettype none

package mexp_pkg;

  localparam int REG_INDEX_W = 1;

  localparam logic [REG_INDEX_W-1:0] REG_MODULUS  = 1'b0;
  localparam logic [REG_INDEX_W-1:0] REG_EXPONENT = 1'b1;

  localparam int FIELD_W = 64;

  localparam logic [FIELD_W-1:0] MODULUS_RESET  = 64'd2;
  localparam logic [FIELD_W-1:0] EXPONENT_RESET = 64'd0;

  typedef struct packed {
    logic busy;
    logic done;
  } mm_status_t;

endpackage

`default_nettype wire

>>> hw/rtl/modular_exponentiation_unit.sv
// One modular multiplication for the base reduction and for each square and multiply step,
// all on one bit-serial shift-add-reduce multiplier.
// A modulus below 2 skips the multiplier: the sequencer goes straight to finish with result 0.
// Throughput: one transaction at a time; in_ready is high only while the sequencer idles,
// and the sequencer holds its result while the previous one still waits on out_ready.
// Reset (rst, synchronous): modulus 2, exponent 0, sequencer idle, no result pending.
`default_nettype none

module modular_exponentiation_unit import mexp_pkg::*; #(
  parameter int WIDTH = 64
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   wr_en,
  input  wire logic [REG_INDEX_W-1:0] wr_index,
  input  wire logic [FIELD_W-1:0]     wr_data,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [FIELD_W-1:0]     block_in,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic      [FIELD_W-1:0]     block_out
);

  localparam int IDX_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_REDUCE = 3'd1;
  localparam logic [2:0] S_SQR    = 3'd2;
  localparam logic [2:0] S_MUL    = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [FIELD_W-1:0] modulus;
  logic [FIELD_W-1:0] exponent;
  logic [2:0]         state;
  logic [IDX_W-1:0]   idx;
  logic [WIDTH-1:0]   base;
  logic [WIDTH-1:0]   acc;
  logic               mm_start;
  logic               mm_issue;
  logic [WIDTH-1:0]   mm_a;
  logic [WIDTH-1:0]   mm_b;
  mm_status_t         mm_stat;
  logic [WIDTH-1:0]   mm_result;
  logic [WIDTH-1:0]   m_w;
  logic [WIDTH-1:0]   e_w;
  logic               in_fire;
  logic               out_free;

  assign m_w      = modulus[WIDTH-1:0];
  assign e_w      = exponent[WIDTH-1:0];
  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus  <= MODULUS_RESET;
      exponent <= EXPONENT_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_MODULUS:  modulus  <= wr_data;
        REG_EXPONENT: exponent <= wr_data;
        default: ;
      endcase
    end
  end

  mexp_modmul #(
    .WIDTH (WIDTH)
  ) u_modmul (
    .clk    (clk),
    .rst    (rst),
    .start  (mm_start),
    .op_a   (mm_a),
    .op_b   (mm_b),
    .op_m   (m_w),
    .status (mm_stat),
    .result (mm_result)
  );

  always_comb begin
    case (state)
      S_IDLE:   mm_issue = in_fire && (m_w >= WIDTH'(2));
      S_REDUCE: mm_issue = mm_stat.done;
      S_SQR:    mm_issue = mm_stat.done && (e_w[idx] || (idx != '0));
      S_MUL:    mm_issue = mm_stat.done && (idx != '0);
      default:  mm_issue = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mm_start  <= 1'b0;
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      mm_start <= mm_issue;
      if (state == S_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (m_w < WIDTH'(2)) begin
              acc   <= '0;
              state <= S_FINISH;
            end else begin
              mm_a  <= WIDTH'(1);
              mm_b  <= block_in[WIDTH-1:0];
              state <= S_REDUCE;
            end
          end
        end
        S_REDUCE: begin
          if (mm_stat.done) begin
            base  <= mm_result;
            mm_a  <= WIDTH'(1);
            mm_b  <= WIDTH'(1);
            idx   <= IDX_W'(WIDTH - 1);
            state <= S_SQR;
          end
        end
        S_SQR: begin
          if (mm_stat.done) begin
            acc <= mm_result;
            if (e_w[idx]) begin
              mm_a  <= mm_result;
              mm_b  <= base;
              state <= S_MUL;
            end else if (idx == '0) begin
              state <= S_FINISH;
            end else begin
              idx  <= idx - IDX_W'(1);
              mm_a <= mm_result;
              mm_b <= mm_result;
            end
          end
        end
        S_MUL: begin
          if (mm_stat.done) begin
            acc <= mm_result;
            if (idx == '0) begin
              state <= S_FINISH;
            end else begin
              idx   <= idx - IDX_W'(1);
              mm_a  <= mm_result;
              mm_b  <= mm_result;
              state <= S_SQR;
            end
          end
        end
        S_FINISH: begin
          if (out_free) begin
            block_out <= FIELD_W'(acc);
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_start_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (state != S_IDLE))
    else $error("accepted transaction left sequencer idle");

  a_done_in_work_state: assert property (@(posedge clk) disable iff (rst)
    mm_stat.done |-> (state == S_REDUCE || state == S_SQR || state == S_MUL))
    else $error("multiplier finished outside a work state");

  a_no_start_while_busy: assert property (@(posedge clk) disable iff (rst)
    mm_start |-> !mm_stat.busy)
    else $error("multiplier restarted while busy");

  a_result_reduced: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && out_free) |=> (block_out[WIDTH-1:0] < m_w || m_w < WIDTH'(2)))
    else $error("result not reduced");

endmodule

`default_nettype wire

>>> hw/rtl/mexp_modmul.sv
`default_nettype none

module mexp_modmul import mexp_pkg::*; #(
  parameter int WIDTH = 64
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [WIDTH-1:0] op_a,
  input  wire logic [WIDTH-1:0] op_b,
  input  wire logic [WIDTH-1:0] op_m,
  output mm_status_t            status,
  output logic      [WIDTH-1:0] result
);

  localparam int CNT_W = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] acc;
  logic [WIDTH-1:0] a_reg;
  logic [WIDTH-1:0] b_reg;
  logic [WIDTH-1:0] m_reg;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;

  logic [WIDTH:0]   dbl;
  logic [WIDTH:0]   dbl_red;
  logic [WIDTH-1:0] addend;
  logic [WIDTH:0]   sum;
  logic [WIDTH:0]   sum_red;
  logic [WIDTH-1:0] acc_next;

  // double, reduce, add the selected operand, reduce
  always_comb begin
    dbl = {acc, 1'b0};
    if (dbl >= {1'b0, m_reg}) begin
      dbl_red = dbl - {1'b0, m_reg};
    end else begin
      dbl_red = dbl;
    end
    addend = b_reg[WIDTH-1] ? a_reg : '0;
    sum = {1'b0, dbl_red[WIDTH-1:0]} + {1'b0, addend};
    if (sum >= {1'b0, m_reg}) begin
      sum_red = sum - {1'b0, m_reg};
    end else begin
      sum_red = sum;
    end
    acc_next = sum_red[WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(WIDTH);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc   <= '0;
      a_reg <= op_a;
      b_reg <= op_b;
      m_reg <= op_m;
    end else if (busy) begin
      acc   <= acc_next;
      b_reg <= {b_reg[WIDTH-2:0], 1'b0};
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign result      = acc;

  a_done_reduced: assert property (@(posedge clk) disable iff (rst)
    done |-> (acc < m_reg))
    else $error("modmul result not reduced");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("modmul done without work");

endmodule

`default_nettype wire
